// ===== rtl/core/prim_min_spanning_tree_top_assert.svh =====
// assertion macros shared by the spanning tree rtl
// no dependencies; included by modules that carry assertions
`ifndef PRIM_MIN_SPANNING_TREE_TOP_ASSERT_SVH
`define PRIM_MIN_SPANNING_TREE_TOP_ASSERT_SVH

// same-cycle implication under synchronous active-low reset
`define MST_ASSERT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spanning tree check failed");

// next-cycle implication under synchronous active-low reset
`define MST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spanning tree check failed");

`endif

// ===== rtl/core/pmst_pkg.sv =====
// shared types and codes for the spanning tree engine
// no dependencies
package pmst_pkg;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_RUN   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADD_RD,
    ST_ADD_CHK,
    ST_ADD_WR2,
    ST_RUN_INIT,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_SWEEP_DEC,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_init;
    logic clr_step;
    logic add_rd;
    logic add_wr1;
    logic add_wr2;
    logic run_init;
    logic sweep_issue;
    logic sweep_next;
    logic out_init;
    logic out_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic run_ok;
    logic sweep_last;
    logic found;
    logic add_upd;
    logic out_is_start;
    logic out_end;
    logic out_taken;
    logic out_last;
  } sts_t;

endpackage

// ===== rtl/core/prim_min_spanning_tree_top.sv =====
// top level of the prim spanning tree engine: config register, sequencer, datapath
// depends on pmst_pkg, pmst_ctrl, pmst_dp, pmst_ram
//
// Holds an undirected weighted graph of up to MAX_VERTICES vertices as a symmetric
// matrix of {present, least weight} words in one ram, and grows a minimum spanning
// tree from a start vertex. One word at a time is taken. Clear graph sweeps the
// matrix one entry a cycle; the same pass runs after reset, with no input word
// taken until it ends. Add edge reads the entry, compares, and, when the stored
// weight changes, makes two mirrored writes on the single write port. In a run
// over n vertices in use, each vertex that joins the tree costs one sweep over all
// n entries of the matrix row and best table, one entry a cycle, with relax and min
// search done on the returning word, plus the SWEEP_END and SWEEP_DEC states to
// close the sweep. Results then leave one word per non-start vertex in rising
// order, each held until the sink is ready. vertex_count lives at byte address 0
// of the apb port and reads back.
module prim_min_spanning_tree_top
  import pmst_pkg::*;
#(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [4:0]                    in_edge_src,
  input  logic [4:0]                    in_edge_dst,
  input  logic signed [WEIGHT_BITS-1:0] in_edge_weight,
  input  logic [4:0]                    in_start_vertex,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4:0]                    out_tree_vertex,
  output logic [4:0]                    out_tree_parent,
  output logic signed [WEIGHT_BITS-1:0] out_link_weight,
  output logic                          out_reached,
  output logic                          out_last
);

  localparam logic REG_VERTEX_COUNT = 1'b0;

  logic [5:0] vertex_count_r;
  logic       reg_sel;
  cmd_t       cmd;
  sts_t       sts;

  // register index is the byte address over four
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;
  assign prdata  = (reg_sel == REG_VERTEX_COUNT) ? {26'd0, vertex_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= 6'd32;
    end else if (psel && penable && pwrite && (reg_sel == REG_VERTEX_COUNT)) begin
      vertex_count_r <= pwdata[5:0];
    end
  end

  pmst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pmst_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .vertex_count    (vertex_count_r),
    .in_edge_src     (in_edge_src),
    .in_edge_dst     (in_edge_dst),
    .in_edge_weight  (in_edge_weight),
    .in_start_vertex (in_start_vertex),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tree_vertex (out_tree_vertex),
    .out_tree_parent (out_tree_parent),
    .out_link_weight (out_link_weight),
    .out_reached     (out_reached),
    .out_last        (out_last)
  );

endmodule

// ===== rtl/core/pmst_ram.sv =====
// generic simple dual port ram, one write port, one registered read port
// no dependencies
module pmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/pmst_ctrl.sv =====
// sequencer for clear, edge add, tree run and result delivery
// depends on pmst_pkg
module pmst_ctrl
  import pmst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  output logic       in_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            FUNC_CLEAR: state_nxt = ST_CLEAR;
            FUNC_ADD:   state_nxt = ST_ADD_RD;
            FUNC_RUN:   state_nxt = ST_RUN_INIT;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR:     if (sts.clr_last) state_nxt = ST_IDLE;
      ST_ADD_RD:    state_nxt = ST_ADD_CHK;
      ST_ADD_CHK:   state_nxt = sts.add_upd ? ST_ADD_WR2 : ST_IDLE;
      ST_ADD_WR2:   state_nxt = ST_IDLE;
      ST_RUN_INIT:  state_nxt = sts.run_ok ? ST_SWEEP : ST_IDLE;
      ST_SWEEP:     if (sts.sweep_last) state_nxt = ST_SWEEP_END;
      ST_SWEEP_END: state_nxt = ST_SWEEP_DEC;
      ST_SWEEP_DEC: state_nxt = sts.found ? ST_SWEEP : ST_OUT_RD;
      ST_OUT_RD: begin
        if (!sts.out_is_start) begin
          state_nxt = ST_OUT_LD;
        end else if (sts.out_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT_LD:    state_nxt = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (sts.out_taken) begin
          state_nxt = sts.out_last ? ST_IDLE : ST_OUT_RD;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
        cmd.clr_init = in_valid && (in_func == FUNC_CLEAR);
      end
      ST_CLEAR:     cmd.clr_step = 1'b1;
      ST_ADD_RD:    cmd.add_rd = 1'b1;
      ST_ADD_CHK:   cmd.add_wr1 = sts.add_upd;
      ST_ADD_WR2:   cmd.add_wr2 = 1'b1;
      ST_RUN_INIT:  cmd.run_init = sts.run_ok;
      ST_SWEEP:     cmd.sweep_issue = 1'b1;
      ST_SWEEP_END: cmd = '0;
      ST_SWEEP_DEC: begin
        cmd.sweep_next = sts.found;
        cmd.out_init = !sts.found;
      end
      ST_OUT_RD:    cmd.out_step = sts.out_is_start && !sts.out_end;
      ST_OUT_LD:    cmd.out_load = 1'b1;
      ST_OUT_WAIT:  cmd.out_step = sts.out_taken && !sts.out_last;
      default:      cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/pmst_dp.sv =====
// datapath: pair matrix, per-vertex best table, min search, result register
// depends on pmst_pkg, pmst_ram and the assertion macro header
`include "prim_min_spanning_tree_top_assert.svh"

module pmst_dp
  import pmst_pkg::*;
#(
  parameter int MAX_VERTICES = 32,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cmd_t                          cmd,
  output sts_t                          sts,
  input  logic [5:0]                    vertex_count,
  input  logic [4:0]                    in_edge_src,
  input  logic [4:0]                    in_edge_dst,
  input  logic signed [WEIGHT_BITS-1:0] in_edge_weight,
  input  logic [4:0]                    in_start_vertex,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [4:0]                    out_tree_vertex,
  output logic [4:0]                    out_tree_parent,
  output logic signed [WEIGHT_BITS-1:0] out_link_weight,
  output logic                          out_reached,
  output logic                          out_last
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int PAW = 2 * VW;
  localparam int WB  = WEIGHT_BITS;
  localparam int BW  = WB + VW;

  // latched input word
  logic [4:0]    edge_src_r, edge_dst_r, start_r;
  logic [WB-1:0] edge_w_r;

  logic [PAW-1:0] clr_cnt_r;
  logic [VW-1:0]  cnt_r, cnt_nxt;
  logic [VW-1:0]  u_r;
  logic           s1_vld_r;
  logic [VW-1:0]  s1_idx_r;
  logic [MAX_VERTICES-1:0] valid_r, valid_nxt, in_tree_r, in_tree_nxt;
  logic           min_found_r;
  logic [VW-1:0]  min_idx_r;
  logic [WB-1:0]  min_w_r;
  logic           out_valid_r;
  logic [4:0]     out_vertex_r, out_parent_r;
  logic [WB-1:0]  out_weight_r;
  logic           out_reached_r, out_last_r;

  logic [VW:0]    n_vert;
  logic [VW-1:0]  nm1;
  logic [VW-1:0]  a_idx, b_idx, start_idx;
  logic           edge_ok;

  logic           pair_we;
  logic [PAW-1:0] pair_waddr, pair_raddr;
  logic [WB:0]    pair_wdata, pair_rd;
  logic           best_we;
  logic [BW-1:0]  best_rd;

  logic [WB-1:0]  pw, bw, cand_w;
  logic           upd, cand_ok, take, last_calc;

  // clamp vertex count into 1 .. MAX_VERTICES
  always_comb begin
    if (vertex_count == 6'd0) begin
      n_vert = (VW+1)'(1);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_vert = (VW+1)'(MAX_VERTICES);
    end else begin
      n_vert = (VW+1)'(vertex_count);
    end
  end

  assign nm1       = VW'(n_vert - (VW+1)'(1));
  assign a_idx     = VW'(edge_src_r);
  assign b_idx     = VW'(edge_dst_r);
  assign start_idx = VW'(start_r);
  assign edge_ok   = (32'(edge_src_r) < MAX_VERTICES) && (32'(edge_dst_r) < MAX_VERTICES);

  // pair matrix: {present, weight}, row-major on {row, col}
  assign pair_we    = cmd.clr_step || cmd.add_wr1 || cmd.add_wr2;
  assign pair_wdata = cmd.clr_step ? '0 : {1'b1, edge_w_r};
  assign pair_raddr = cmd.add_rd ? {a_idx, b_idx} : {u_r, cnt_r};

  always_comb begin
    if (cmd.clr_step) begin
      pair_waddr = clr_cnt_r;
    end else if (cmd.add_wr1) begin
      pair_waddr = {a_idx, b_idx};
    end else begin
      pair_waddr = {b_idx, a_idx};
    end
  end

  pmst_ram #(.WIDTH(WB + 1), .DEPTH(2 ** PAW)) u_pair_ram (
    .clk   (clk),
    .we    (pair_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .raddr (pair_raddr),
    .rdata (pair_rd)
  );

  // best table: {weight, parent}
  pmst_ram #(.WIDTH(BW), .DEPTH(2 ** VW)) u_best_ram (
    .clk   (clk),
    .we    (best_we),
    .waddr (s1_idx_r),
    .wdata ({pw, u_r}),
    .raddr (cnt_r),
    .rdata (best_rd)
  );

  // relax and min tracking on the returning sweep word
  assign pw      = pair_rd[WB-1:0];
  assign bw      = best_rd[BW-1:VW];
  assign upd     = s1_vld_r && !in_tree_r[s1_idx_r] && pair_rd[WB] &&
                   (!valid_r[s1_idx_r] || ($signed(pw) < $signed(bw)));
  assign best_we = upd;
  assign cand_w  = upd ? pw : bw;
  assign cand_ok = s1_vld_r && !in_tree_r[s1_idx_r] && (valid_r[s1_idx_r] || upd);
  assign take    = cand_ok && (!min_found_r || ($signed(cand_w) < $signed(min_w_r)));

  assign last_calc = (cnt_r == nm1) ||
                     (((VW+1)'(cnt_r) + (VW+1)'(1) == (VW+1)'(nm1)) && (start_idx == nm1));

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.run_init || cmd.sweep_next || cmd.out_init) begin
      cnt_nxt = '0;
    end else if (cmd.sweep_issue || cmd.out_step) begin
      cnt_nxt = cnt_r + VW'(1);
    end
  end

  always_comb begin
    valid_nxt   = valid_r;
    in_tree_nxt = in_tree_r;
    if (cmd.run_init) begin
      valid_nxt = '0;
      in_tree_nxt = '0;
      valid_nxt[start_idx] = 1'b1;
      in_tree_nxt[start_idx] = 1'b1;
    end else if (cmd.sweep_next) begin
      in_tree_nxt[min_idx_r] = 1'b1;
    end
    if (upd) begin
      valid_nxt[s1_idx_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      s1_vld_r    <= 1'b0;
      valid_r     <= '0;
      in_tree_r   <= '0;
      min_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_init) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + PAW'(1);
      end
      cnt_r     <= cnt_nxt;
      s1_vld_r  <= cmd.sweep_issue;
      valid_r   <= valid_nxt;
      in_tree_r <= in_tree_nxt;
      if (cmd.run_init || cmd.sweep_next) begin
        min_found_r <= 1'b0;
      end else if (take) begin
        min_found_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      edge_src_r <= in_edge_src;
      edge_dst_r <= in_edge_dst;
      edge_w_r   <= in_edge_weight;
      start_r    <= in_start_vertex;
    end
    if (cmd.run_init) begin
      u_r <= start_idx;
    end else if (cmd.sweep_next) begin
      u_r <= min_idx_r;
    end
    s1_idx_r <= cnt_r;
    if (take) begin
      min_idx_r <= s1_idx_r;
      min_w_r   <= cand_w;
    end
    if (cmd.out_load) begin
      out_vertex_r  <= 5'(cnt_r);
      out_reached_r <= valid_r[cnt_r];
      out_parent_r  <= valid_r[cnt_r] ? 5'(best_rd[VW-1:0]) : 5'd0;
      out_weight_r  <= valid_r[cnt_r] ? bw : '0;
      out_last_r    <= last_calc;
    end
  end

  always_comb begin
    sts = '0;
    sts.clr_last     = (clr_cnt_r == '1);
    sts.run_ok       = (32'(start_r) < 32'(n_vert));
    sts.sweep_last   = (cnt_r == nm1);
    sts.found        = min_found_r;
    sts.add_upd      = edge_ok && (!pair_rd[WB] || ($signed(edge_w_r) < $signed(pw)));
    sts.out_is_start = (cnt_r == start_idx);
    sts.out_end      = (cnt_r == nm1);
    sts.out_taken    = out_valid_r && out_ready;
    sts.out_last     = out_last_r;
  end

  assign out_valid       = out_valid_r;
  assign out_tree_vertex = out_vertex_r;
  assign out_tree_parent = out_parent_r;
  assign out_link_weight = out_weight_r;
  assign out_reached     = out_reached_r;
  assign out_last        = out_last_r;

  `MST_ASSERT(a_no_tree_relax, clk, rst_n, best_we, !in_tree_r[s1_idx_r])
  `MST_ASSERT(a_min_outside_tree, clk, rst_n, min_found_r, !in_tree_r[min_idx_r])
  `MST_ASSERT_NEXT(a_mirror_write, clk, rst_n, cmd.add_wr1, cmd.add_wr2)

endmodule
